// ===== sv/spq_pkg.sv =====
package spq_pkg;

    localparam int TAG_W    = 16;
    localparam int KEY_W    = 16;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;

    typedef enum logic [0:0] {
        OP_ENQ = 1'b0,
        OP_DEQ = 1'b1
    } spq_op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } spq_status_t;

    // Broadcast from the top level to every cell
    typedef struct packed {
        logic             enq;
        logic             deq;
        logic [TAG_W-1:0] new_tag;
        logic [KEY_W-1:0] new_key;
    } spq_ctrl_t;

endpackage

// ===== sv/spq_req_if.sv =====
interface spq_req_if
    import spq_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [0:0]       op;
    logic [TAG_W-1:0] job_tag;
    logic [KEY_W-1:0] page_count;

    modport source (output valid, output op, output job_tag, output page_count, input ready);
    modport sink   (input valid, input op, input job_tag, input page_count, output ready);
endinterface

// ===== sv/spq_rsp_if.sv =====
interface spq_rsp_if
    import spq_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [TAG_W-1:0]    out_tag;
    logic [KEY_W-1:0]    out_pages;
    logic [OCC_W-1:0]    occupancy;
    logic                is_empty;

    modport source (output valid, output status, output out_tag, output out_pages,
                    output occupancy, output is_empty, input ready);
    modport sink   (input valid, input status, input out_tag, input out_pages,
                    input occupancy, input is_empty, output ready);
endinterface

// ===== sv/spq_cell.sv =====
module spq_cell
    import spq_pkg::*;
(
    input  logic             clk,
    input  spq_ctrl_t        ctrl,
    input  logic             occupied,
    input  logic             left_gt,
    input  logic [TAG_W-1:0] left_tag,
    input  logic [KEY_W-1:0] left_key,
    input  logic [TAG_W-1:0] right_tag,
    input  logic [KEY_W-1:0] right_key,
    output logic             gt,
    output logic [TAG_W-1:0] tag,
    output logic [KEY_W-1:0] key
);

    logic [TAG_W-1:0] tag_reg;
    logic [KEY_W-1:0] key_reg;
    logic [TAG_W-1:0] tag_next;
    logic [KEY_W-1:0] key_next;

    // An empty cell or a larger key yields its place to the new job
    assign gt  = !occupied || (key_reg > ctrl.new_key);
    assign tag = tag_reg;
    assign key = key_reg;

    // Choose: hold, take the new job, shift in from the left, or shift in from the right
    always_comb
    begin
        tag_next = tag_reg;
        key_next = key_reg;
        if (ctrl.enq && gt)
        begin
            if (left_gt)
            begin
                tag_next = left_tag;
                key_next = left_key;
            end
            else
            begin
                tag_next = ctrl.new_tag;
                key_next = ctrl.new_key;
            end
        end
        else if (ctrl.deq)
        begin
            tag_next = right_tag;
            key_next = right_key;
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg <= tag_next;
        key_reg <= key_next;
    end

endmodule

// ===== sv/sorted_priority_queue_top.sv =====
// Sorted priority queue of up to DEPTH jobs, ordered by ascending page count with
// ties leaving first in, first out. Each transfer on req (op 0 enqueue, 1 dequeue)
// produces exactly one transfer on rsp carrying status, the dequeued job (zero
// otherwise), and the occupancy after the operation. The jobs sit in a row of
// cells that all compare against the incoming key at once and shift left or right
// together, so one operation completes per clock cycle while rsp is not stalled; the
// result appears in an output register in the cycle after its request transfer, and req stays ready while
// that register is empty or being drained. Enqueue on a full queue is dropped with
// status full; dequeue on an empty queue returns status empty.
module sorted_priority_queue_top
    import spq_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic clk,
    input  logic rst_n,
    spq_req_if.sink   req,
    spq_rsp_if.source rsp
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    logic                rsp_valid_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [TAG_W-1:0]    out_tag_reg;
    logic [KEY_W-1:0]    out_pages_reg;
    logic [OCC_W-1:0]    occupancy_reg;
    logic                is_empty_reg;

    logic                fire;
    logic                full;
    logic                empty;
    spq_ctrl_t           ctrl;
    logic [STATUS_W-1:0] status_new;

    logic [DEPTH-1:0]             cell_gt;
    logic [DEPTH-1:0][TAG_W-1:0]  cell_tag;
    logic [DEPTH-1:0][KEY_W-1:0]  cell_key;

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign fire      = req.valid && req.ready;
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);

    // Decode the operation and the count after it
    always_comb
    begin
        ctrl.enq     = fire && (req.op == OP_ENQ) && !full;
        ctrl.deq     = fire && (req.op == OP_DEQ) && !empty;
        ctrl.new_tag = req.job_tag;
        ctrl.new_key = req.page_count;
        count_next   = count_reg;
        status_new   = ST_OK;
        if (ctrl.enq)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (ctrl.deq)
        begin
            count_next = count_reg - 1'b1;
        end
        if (req.op == OP_ENQ && full)
        begin
            status_new = ST_FULL;
        end
        else if (req.op == OP_DEQ && empty)
        begin
            status_new = ST_EMPTY;
        end
    end

    // Row of cells, head at index zero
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic             occupied;
        logic             left_gt;
        logic [TAG_W-1:0] left_tag;
        logic [KEY_W-1:0] left_key;
        logic [TAG_W-1:0] right_tag;
        logic [KEY_W-1:0] right_key;

        assign occupied = (count_reg > CNT_W'(i));

        if (i == 0)
        begin : g_head
            assign left_gt  = 1'b0;
            assign left_tag = cell_tag[i];
            assign left_key = cell_key[i];
        end
        else
        begin : g_body
            assign left_gt  = cell_gt[i-1];
            assign left_tag = cell_tag[i-1];
            assign left_key = cell_key[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign right_tag = cell_tag[i];
            assign right_key = cell_key[i];
        end
        else
        begin : g_inner
            assign right_tag = cell_tag[i+1];
            assign right_key = cell_key[i+1];
        end

        spq_cell u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .occupied  (occupied),
            .left_gt   (left_gt),
            .left_tag  (left_tag),
            .left_key  (left_key),
            .right_tag (right_tag),
            .right_key (right_key),
            .gt        (cell_gt[i]),
            .tag       (cell_tag[i]),
            .key       (cell_key[i])
        );
    end

    // Hold the occupancy count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Hold the result until the sink takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            status_reg    <= status_new;
            out_tag_reg   <= ctrl.deq ? cell_tag[0] : '0;
            out_pages_reg <= ctrl.deq ? cell_key[0] : '0;
            occupancy_reg <= OCC_W'(count_next);
            is_empty_reg  <= (count_next == '0);
        end
    end

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.status    = status_reg;
    assign rsp.out_tag   = out_tag_reg;
    assign rsp.out_pages = out_pages_reg;
    assign rsp.occupancy = occupancy_reg;
    assign rsp.is_empty  = is_empty_reg;

endmodule

// ===== sv/spq_checker.sv =====
module spq_checker
    import spq_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input logic                clk,
    input logic                rst_n,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input logic [STATUS_W-1:0] status,
    input logic [TAG_W-1:0]    out_tag,
    input logic [KEY_W-1:0]    out_pages,
    input logic [OCC_W-1:0]    occupancy,
    input logic                is_empty
);

    // A stalled result stays offered
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("rsp valid dropped before transfer");

    // Emptiness flag agrees with occupancy
    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (is_empty == (occupancy == '0)))
        else $error("is_empty disagrees with occupancy");

    // Dequeue on empty leaves the queue empty
    a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == ST_EMPTY |-> is_empty && out_tag == '0 && out_pages == '0)
        else $error("empty status with nonempty queue or data");

    // A dropped enqueue reports a full queue
    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == ST_FULL
            |-> occupancy == OCC_W'(DEPTH) && out_tag == '0 && out_pages == '0)
        else $error("full status with queue not full or data");

endmodule

bind sorted_priority_queue_top spq_checker #(.DEPTH(DEPTH)) u_spq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .status    (rsp.status),
    .out_tag   (rsp.out_tag),
    .out_pages (rsp.out_pages),
    .occupancy (rsp.occupancy),
    .is_empty  (rsp.is_empty)
);

// ===== tb/sv/tb_top.sv =====
module tb_top;
    import spq_pkg::*;

    localparam int DEPTH        = 16;
    localparam int RANDOM_ITEMS = 1650;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PRINT_CAP    = 20;
    localparam int N_DIRECTED   = 16;

    // One result transfer as the block reports it
    typedef struct packed {
        spq_status_t       status;
        logic [TAG_W-1:0]  tag;
        logic [KEY_W-1:0]  pages;
        logic [OCC_W-1:0]  occ;
        logic              empty;
    } spq_result_t;

    // Directed stimulus row; reps repeats the row with tag + n and pages - n * step
    typedef struct packed {
        spq_op_t           op;
        logic [TAG_W-1:0]  tag;
        logic [KEY_W-1:0]  pages;
        logic [4:0]        reps;
        logic [KEY_W-1:0]  step;
        logic              typed;
        spq_result_t       want;
    } stim_row_t;

    // Typed answer carried alongside a request, used instead of the queue model
    typedef struct packed {
        logic              typed;
        spq_result_t       want;
    } typed_check_t;

    typedef enum int {
        KEYS_ANY,
        KEYS_NARROW,
        KEYS_EXTREME,
        KEYS_FIXED
    } key_mode_t;

    localparam spq_result_t NO_RESULT = '{ST_OK, 16'h0000, 16'h0000, 5'd0, 1'b0};
    localparam typed_check_t NO_CHECK = '{1'b0, NO_RESULT};

    localparam stim_row_t DIRECTED_ROWS [0:N_DIRECTED-1] = '{
        // dequeue right after reset
        '{OP_DEQ, 16'h0000, 16'h0000, 5'd1,  16'd0, 1'b1,
          '{ST_EMPTY, 16'h0000, 16'h0000, 5'd0, 1'b1}},
        // largest key, then smallest key twice (tie at the head)
        '{OP_ENQ, 16'hFFFF, 16'hFFFF, 5'd1,  16'd0, 1'b1,
          '{ST_OK, 16'h0000, 16'h0000, 5'd1, 1'b0}},
        '{OP_ENQ, 16'h0000, 16'h0000, 5'd1,  16'd0, 1'b1,
          '{ST_OK, 16'h0000, 16'h0000, 5'd2, 1'b0}},
        '{OP_ENQ, 16'h1234, 16'h0000, 5'd1,  16'd0, 1'b1,
          '{ST_OK, 16'h0000, 16'h0000, 5'd3, 1'b0}},
        '{OP_DEQ, 16'h0000, 16'h0000, 5'd1,  16'd0, 1'b1,
          '{ST_OK, 16'h0000, 16'h0000, 5'd2, 1'b0}},
        '{OP_DEQ, 16'h0000, 16'h0000, 5'd1,  16'd0, 1'b1,
          '{ST_OK, 16'h1234, 16'h0000, 5'd1, 1'b0}},
        '{OP_DEQ, 16'h0000, 16'h0000, 5'd1,  16'd0, 1'b1,
          '{ST_OK, 16'hFFFF, 16'hFFFF, 5'd0, 1'b1}},
        // fill with falling keys so every insert lands at the head
        '{OP_ENQ, 16'h0100, 16'h8000, 5'd16, 16'd1, 1'b0, NO_RESULT},
        // full queue drops even the smallest key
        '{OP_ENQ, 16'hBEEF, 16'h0000, 5'd1,  16'd0, 1'b1,
          '{ST_FULL, 16'h0000, 16'h0000, 5'd16, 1'b0}},
        '{OP_DEQ, 16'h0000, 16'h0000, 5'd16, 16'd0, 1'b0, NO_RESULT},
        '{OP_DEQ, 16'h0000, 16'h0000, 5'd1,  16'd0, 1'b1,
          '{ST_EMPTY, 16'h0000, 16'h0000, 5'd0, 1'b1}},
        // equal keys leave in arrival order; then a new head and a new tail
        '{OP_ENQ, 16'h0200, 16'h0042, 5'd6,  16'd0, 1'b0, NO_RESULT},
        '{OP_ENQ, 16'hAAAA, 16'h0041, 5'd1,  16'd0, 1'b0, NO_RESULT},
        '{OP_ENQ, 16'h5555, 16'h0043, 5'd1,  16'd0, 1'b0, NO_RESULT},
        '{OP_DEQ, 16'h0000, 16'h0000, 5'd8,  16'd0, 1'b0, NO_RESULT},
        '{OP_DEQ, 16'h0000, 16'h0000, 5'd1,  16'd0, 1'b1,
          '{ST_EMPTY, 16'h0000, 16'h0000, 5'd0, 1'b1}}
    };

    logic clk;
    logic rst_n;

    spq_req_if req_bus ();
    spq_rsp_if rsp_bus ();

    sorted_priority_queue_top #(
        .DEPTH (DEPTH)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    // Queue model state
    logic [TAG_W-1:0] job_tags  [0:DEPTH-1];
    logic [KEY_W-1:0] job_pages [0:DEPTH-1];
    int               job_count;

    spq_result_t  expected_results [$];
    typed_check_t typed_checks     [$];

    int cycle_count;
    int mismatches;
    int items_issued;
    int results_checked;
    int enq_count;
    int deq_count;
    int full_drops;
    int empty_deqs;
    int peak_occ;
    int burst_left;
    bit gaps_on;

    spq_result_t  model_out;
    spq_result_t  want_now;
    typed_check_t check_now;

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // Apply one operation to the queue model and return what the block should report
    function automatic spq_result_t queue_model_step(spq_op_t op, logic [TAG_W-1:0] tag,
                                                     logic [KEY_W-1:0] pages);
        spq_result_t r;
        int          i;
        r = NO_RESULT;
        if (op == OP_ENQ)
        begin
            if (job_count >= DEPTH)
                r.status = ST_FULL;
            else
            begin
                // shift larger keys up; equal keys stay ahead of the new job
                i = job_count;
                while (i > 0 && job_pages[i-1] > pages)
                begin
                    job_tags[i]  = job_tags[i-1];
                    job_pages[i] = job_pages[i-1];
                    i--;
                end
                job_tags[i]  = tag;
                job_pages[i] = pages;
                job_count++;
            end
        end
        else
        begin
            if (job_count == 0)
                r.status = ST_EMPTY;
            else
            begin
                r.tag   = job_tags[0];
                r.pages = job_pages[0];
                for (i = 1; i < job_count; i++)
                begin
                    job_tags[i-1]  = job_tags[i];
                    job_pages[i-1] = job_pages[i];
                end
                job_count--;
            end
        end
        r.occ   = job_count[OCC_W-1:0];
        r.empty = (job_count == 0);
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        if (mismatches < PRINT_CAP)
            $display("MISMATCH cycle %0d result %0d: %s got %h expected %h",
                     cycle_count, results_checked, what, got, want);
        mismatches++;
    endtask

    task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
        if (got !== want)
            report_mismatch(name, got, want);
    endtask

    // Predict on each request transfer, compare on each response transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_bus.valid && req_bus.ready)
            begin
                model_out = queue_model_step(spq_op_t'(req_bus.op), req_bus.job_tag,
                                             req_bus.page_count);
                check_now = typed_checks.pop_front();
                expected_results.push_back(check_now.typed ? check_now.want : model_out);
                if (spq_op_t'(req_bus.op) == OP_ENQ)
                begin
                    enq_count++;
                    if (model_out.status == ST_FULL)
                        full_drops++;
                end
                else
                begin
                    deq_count++;
                    if (model_out.status == ST_EMPTY)
                        empty_deqs++;
                end
                if (int'(model_out.occ) > peak_occ)
                    peak_occ = int'(model_out.occ);
            end
            if (rsp_bus.valid && rsp_bus.ready)
            begin
                results_checked++;
                if (expected_results.size() == 0)
                    report_mismatch("response with nothing pending", 16'h0, 16'h0);
                else
                begin
                    want_now = expected_results.pop_front();
                    check_field("status",    16'(rsp_bus.status),    16'(want_now.status));
                    check_field("out_tag",   rsp_bus.out_tag,        want_now.tag);
                    check_field("out_pages", rsp_bus.out_pages,      want_now.pages);
                    check_field("occupancy", 16'(rsp_bus.occupancy), 16'(want_now.occ));
                    check_field("is_empty",  16'(rsp_bus.is_empty),  16'(want_now.empty));
                end
            end
        end
    end

    // Stall the response side on a rotating mask, reloaded when its hold count runs out
    initial
    begin : rsp_stall_pattern
        logic [31:0] stall_mask;
        int          hold;
        rsp_bus.ready <= 1'b0;
        stall_mask = 32'hFFFF_FFFF;
        hold = 0;
        forever
        begin
            @(posedge clk);
            if (hold == 0)
            begin
                hold = 100;
                case ($urandom_range(0, 3))
                    0: stall_mask = 32'hFFFF_FFFF;
                    1: stall_mask = $urandom;
                    2: stall_mask = $urandom & $urandom;
                    default: stall_mask = $urandom | $urandom;
                endcase
                stall_mask[0] = 1'b1;
            end
            hold--;
            rsp_bus.ready <= stall_mask[0];
            stall_mask = {stall_mask[0], stall_mask[31:1]};
        end
    end

    // Present one request and hold it until the transfer; may open a gap between bursts
    task automatic issue_job(spq_op_t op, logic [TAG_W-1:0] tag, logic [KEY_W-1:0] pages,
                             typed_check_t chk);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = gaps_on ? $urandom_range(0, 5) : 0;
            if (gap != 0)
            begin
                req_bus.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        typed_checks.push_back(chk);
        items_issued++;
        req_bus.valid      <= 1'b1;
        req_bus.op         <= op;
        req_bus.job_tag    <= tag;
        req_bus.page_count <= pages;
        @(posedge clk);
        while (!req_bus.ready)
            @(posedge clk);
    endtask

    function automatic logic [KEY_W-1:0] pick_pages(key_mode_t mode, logic [KEY_W-1:0] fixed);
        logic [KEY_W-1:0] p;
        case (mode)
            KEYS_NARROW:
                p = KEY_W'($urandom_range(0, 7));
            KEYS_EXTREME:
                case ($urandom_range(0, 3))
                    0: p = 16'h0000;
                    1: p = 16'hFFFF;
                    2: p = 16'h0001;
                    default: p = 16'hFFFE;
                endcase
            KEYS_FIXED:
                p = fixed;
            default:
                p = KEY_W'($urandom_range(0, 65535));
        endcase
        return p;
    endfunction

    initial
    begin : stimulus
        int               r;
        int               k;
        int               seg_len;
        int               enq_pct;
        int               random_sent;
        logic [15:0]      rep_idx;
        key_mode_t        key_mode;
        logic [KEY_W-1:0] fixed_key;
        spq_op_t          op;

        rst_n              <= 1'b0;
        req_bus.valid      <= 1'b0;
        req_bus.op         <= OP_ENQ;
        req_bus.job_tag    <= '0;
        req_bus.page_count <= '0;
        job_count       = 0;
        cycle_count     = 0;
        mismatches      = 0;
        items_issued    = 0;
        results_checked = 0;
        enq_count       = 0;
        deq_count       = 0;
        full_drops      = 0;
        empty_deqs      = 0;
        peak_occ        = 0;
        burst_left      = 0;
        gaps_on         = 1'b1;
        random_sent     = 0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table
        for (r = 0; r < N_DIRECTED; r++)
        begin
            for (rep_idx = '0; rep_idx < 16'(DIRECTED_ROWS[r].reps); rep_idx++)
                issue_job(DIRECTED_ROWS[r].op, DIRECTED_ROWS[r].tag + rep_idx,
                          DIRECTED_ROWS[r].pages - rep_idx * DIRECTED_ROWS[r].step,
                          '{DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].want});
        end

        // Random segments: fill-heavy, drain-heavy and balanced mixes over several key spreads
        while (random_sent < RANDOM_ITEMS)
        begin
            seg_len = $urandom_range(20, 80);
            case ($urandom_range(0, 3))
                0: enq_pct = 85;
                1: enq_pct = 15;
                2: enq_pct = 50;
                default: enq_pct = 65;
            endcase
            key_mode  = key_mode_t'($urandom_range(0, 3));
            fixed_key = KEY_W'($urandom_range(0, 65535));
            gaps_on   = ($urandom_range(0, 3) != 0);
            for (k = 0; k < seg_len && random_sent < RANDOM_ITEMS; k++)
            begin
                op = ($urandom_range(0, 99) < enq_pct) ? OP_ENQ : OP_DEQ;
                issue_job(op, TAG_W'($urandom_range(0, 65535)), pick_pages(key_mode, fixed_key),
                          NO_CHECK);
                random_sent++;
            end
        end
        req_bus.valid <= 1'b0;

        // Drain, then allow the output register to settle
        while (results_checked < items_issued)
            @(posedge clk);
        repeat (4) @(posedge clk);

        if (expected_results.size() != 0)
            report_mismatch("expectations left over", 16'(expected_results.size()), 16'h0);

        $display("Run covered %0d jobs: %0d enqueues (%0d dropped on full), %0d dequeues",
                 items_issued, enq_count, full_drops, deq_count);
        $display("  (%0d on empty), peak occupancy %0d, %0d mismatches in %0d cycles",
                 empty_deqs, peak_occ, mismatches, cycle_count);
        if (mismatches == 0)
            $display("** sorted_priority_queue_top: PASSED **");
        else
            $display("** sorted_priority_queue_top: FAILED **");
        $finish;
    end

    // End a hung run
    initial
    begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Timeout after %0d cycles with %0d of %0d results checked",
                 cycle_count, results_checked, items_issued);
        $display("** sorted_priority_queue_top: FAILED **");
        $finish;
    end

endmodule
